// File: src/calendar_date_arithmetic_core_assert.svh
// Assertion macros for the calendar date arithmetic core.
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH
`ifndef SYNTH
`define CDA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CDA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CDA_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define CDA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: src/cda_pkg.sv
// Package with types, constants and calendar functions for the date core.
package cda_pkg;

    localparam int YearMax = 9999;
    localparam logic [21:0] DiffMax = 22'h3FFFFF;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_SUB  = 2'd1,
        REQ_DIFF = 2'd2,
        REQ_CMP  = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [19:0] day_count;
    } cda_req_t;

    typedef struct packed {
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [13:0] res_year;
        logic [21:0] day_diff;
        logic        is_less;
        logic        is_equal;
        logic        range_error;
    } cda_res_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request, serial of A (plus or minus the day count) into accumulator
        logic add_b;     // subtract serial of B for difference and compare
        logic year_step; // advance one year of the serial walk
        logic month_step;
        logic finish;    // form the result register
    } cda_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_walk;   // request needs the serial-to-date walk
        logic neg;       // serial below zero
        logic year_done; // remaining serial fits in the current year
        logic year_over; // year went past the maximum
        logic month_done;
    } cda_sts_t;

    // Quotient by 100 through a reciprocal multiply; exact for any 15-bit value.
    function automatic logic [8:0] div100(input logic [14:0] x);
        logic [27:0] p;
        p = {13'd0, x} * 28'd5243;
        return p[27:19];
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        logic [8:0] q;
        logic       m4, m100, m400;
        q    = div100({1'b0, y});
        m4   = (y[1:0] == 2'd0);
        m100 = (({6'd0, q} * 15'd100) == {1'b0, y});
        m400 = m100 && (q[1:0] == 2'd0);
        return m4 && (!m100 || m400);
    endfunction

    // Days in years 0 .. y-1.
    function automatic logic [22:0] days_before_year(input logic [13:0] y);
        logic [22:0] yy;
        logic [14:0] y99, y399;
        yy   = {9'd0, y};
        y99  = {1'b0, y} + 15'd99;
        y399 = {1'b0, y} + 15'd399;
        return 23'd365 * yy + ((yy + 23'd3) >> 2) - {14'd0, div100(y99)}
            + {14'd0, div100(y399 >> 2)};
    endfunction

    // Days in months 0 .. m-1 of a year.
    function automatic logic [8:0] days_before_month(input logic [3:0] m,
                                                     input logic leap);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        if (leap && m >= 4'd2)
            d = d + 9'd1;
        return d;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1:                     d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  d = 5'd30;
            default:                  d = 5'd31;
        endcase
        return d;
    endfunction

    // Two's complement serial; day zero of January in year 0 gives -1.
    function automatic logic [25:0] date_serial(input logic [4:0] d,
                                                input logic [3:0] m,
                                                input logic [13:0] y);
        logic [3:0] mm;
        mm = (m > 4'd11) ? 4'd11 : m;
        return {3'b000, days_before_year(y)}
            + {17'd0, days_before_month(mm, is_leap(y))} + {21'd0, d} - 26'd1;
    endfunction

endpackage

// File: src/cda_if.sv
// Valid/ready channel interface carrying one payload.
interface cda_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/cda_datapath.sv
// Datapath: date serials, year and month walk, result register.
module cda_datapath
    import cda_pkg::*;
(
    input  logic     clk,
    input  cda_req_t req,
    input  cda_cmd_t cmd,
    output cda_sts_t sts,
    output cda_res_t res
);

    cda_req_t           req_reg;
    logic signed [25:0] acc_reg;   // serial / remaining days
    logic [13:0]        year_reg;
    logic [3:0]         month_reg;
    cda_res_t           res_reg;
    cda_res_t           res_next;
    logic [8:0]         ylen;
    logic [4:0]         mlen;
    logic               leap;
    logic               lt;
    logic signed [25:0] sa;
    logic signed [25:0] mag;

    assign leap = is_leap(year_reg);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_days(month_reg, leap);
    assign sa   = $signed(date_serial(req.day_a, req.month_a, req.year_a));
    assign mag  = acc_reg[25] ? -acc_reg : acc_reg;

    assign sts.is_walk    = (req_reg.req_type == REQ_ADD) || (req_reg.req_type == REQ_SUB);
    assign sts.neg        = acc_reg[25];
    assign sts.year_done  = acc_reg < $signed({17'd0, ylen});
    assign sts.year_over  = year_reg > 14'(YearMax);
    assign sts.month_done = (month_reg == 4'd11) || (acc_reg < $signed({21'd0, mlen}));

    always_comb
    begin
        if (req_reg.year_a != req_reg.year_b)
            lt = req_reg.year_a < req_reg.year_b;
        else if (req_reg.month_a != req_reg.month_b)
            lt = req_reg.month_a < req_reg.month_b;
        else
            lt = req_reg.day_a < req_reg.day_b;
    end

    // Result of the request in flight; the difference saturates at its field width.
    always_comb
    begin
        res_next = '0;
        case (req_reg.req_type)
            REQ_ADD, REQ_SUB:
            begin
                if (sts.neg || sts.year_over)
                    res_next.range_error = 1'b1;
                else
                begin
                    res_next.res_day   = acc_reg[4:0] + 5'd1;
                    res_next.res_month = month_reg;
                    res_next.res_year  = year_reg;
                end
            end
            REQ_DIFF:
            begin
                if (mag > $signed({4'd0, DiffMax}))
                    res_next.day_diff = DiffMax;
                else
                    res_next.day_diff = mag[21:0];
            end
            default:
            begin
                res_next.is_less  = lt;
                res_next.is_equal = (req_reg.year_a == req_reg.year_b)
                    && (req_reg.month_a == req_reg.month_b)
                    && (req_reg.day_a == req_reg.day_b);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            year_reg  <= '0;
            month_reg <= '0;
            case (req.req_type)
                REQ_ADD: acc_reg <= sa + $signed({6'd0, req.day_count});
                REQ_SUB: acc_reg <= sa - $signed({6'd0, req.day_count});
                default: acc_reg <= sa;
            endcase
        end
        else if (cmd.add_b)
        begin
            acc_reg <= acc_reg - $signed(
                date_serial(req_reg.day_b, req_reg.month_b, req_reg.year_b));
        end
        else if (cmd.year_step)
        begin
            acc_reg  <= acc_reg - $signed({17'd0, ylen});
            year_reg <= year_reg + 14'd1;
        end
        else if (cmd.month_step)
        begin
            acc_reg   <= acc_reg - $signed({21'd0, mlen});
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.finish)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: src/cda_ctrl.sv
// Controller state machine sequencing one request at a time.
`include "calendar_date_arithmetic_core_assert.svh"
module cda_ctrl
    import cda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  cda_sts_t sts,
    output cda_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_YEAR  = 6'b000100,
        ST_MONTH = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (sts.is_walk)
                    state_next = sts.neg ? ST_FIN : ST_YEAR;
                else
                begin
                    cmd.add_b  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_YEAR:
            begin
                if (sts.year_over)
                    state_next = ST_FIN;
                else if (sts.year_done)
                    state_next = ST_MONTH;
                else
                    cmd.year_step = 1'b1;
            end
            ST_MONTH:
            begin
                if (sts.month_done)
                    state_next = ST_FIN;
                else
                    cmd.month_step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `CDA_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `CDA_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `CDA_ASSERT_NEXT(a_fin, clk, rst_n, cmd.finish, out_valid)
    `CDA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

// File: src/calendar_date_arithmetic_core.sv
// Top level of the calendar date arithmetic core.
// The block takes one request on the req channel: a type (add, subtract,
// difference, compare), two dates A and B, and a day count. It returns
// one result on the res channel with the date, the day difference, the
// compare flags and a range error flag.
// Dates are turned into day serials counted from 1 January of year 0.
// Add and subtract then walk the serial back into a date, one year per
// cycle and then one month per cycle; difference and compare requests
// skip the walk and go from setup straight to the finish state.
// The block works on one request at a time; req ready is high only while
// it is idle, and the year walk is the loop that sets the latency.
// The result is held in a register and stays on res while the receiver
// stalls; the next request is taken once the result has been taken.
// Reset clears the controller to idle; no request is pending afterward.
module calendar_date_arithmetic_core
    import cda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cda_if.sink  req,
    cda_if.source res
);

    cda_cmd_t cmd;
    cda_sts_t sts;
    cda_res_t res_data;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cda_datapath u_dp (
        .clk (clk),
        .req (req.data),
        .cmd (cmd),
        .sts (sts),
        .res (res_data)
    );

    assign res.data = res_data;

endmodule

// File: sim/tb_calendar_date_arithmetic_core.sv
// Self-checking testbench for the calendar date arithmetic core.
`timescale 1ns / 1ps

module tb_calendar_date_arithmetic_core;
    import cda_pkg::*;

    // One request waiting in the stimulus queue. When hold is set, the driver
    // keeps it back until every outstanding result has been returned.
    typedef struct {
        cda_req_t req;
        bit       hold;
    } queued_req_t;

    localparam int  NumRandom   = 200;
    localparam longint CycleLimit = 30000000;

    logic clk;
    logic rst_n;

    cda_if #(.payload_t(cda_req_t)) req_if (clk);
    cda_if #(.payload_t(cda_res_t)) res_if (clk);

    calendar_date_arithmetic_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .res   (res_if.source)
    );

    queued_req_t request_queue[$];
    cda_res_t    pending_results[$];

    int     mismatch_count;
    int     result_count;
    int     accepted_count;
    int     sent_by_type[4];
    int     range_errors_seen;
    longint cycle_count;
    bit     stimulus_done;

    // Calendar arithmetic for the expected results. Every date becomes a day
    // serial counted from 1 January of year 0 on the proleptic Gregorian
    // calendar, with year 0 a leap year.
    function automatic bit leap_year(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint month_length(int m, longint y);
        int lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 1 && leap_year(y))
            return 29;
        return lengths[m];
    endfunction

    function automatic longint year_start(longint y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // Months above December clamp to December; the day adds in linearly, so
    // day zero and overlong days roll into the neighboring months.
    function automatic longint day_number(logic [4:0] d, logic [3:0] m, logic [13:0] y);
        longint s;
        int     mm;
        s  = year_start(longint'(y));
        mm = (m > 4'd11) ? 11 : int'(m);
        for (int i = 0; i < mm; i++)
            s += month_length(i, longint'(y));
        return s + longint'(d) - 1;
    endfunction

    function automatic cda_res_t predict_date_result(cda_req_t r);
        cda_res_t  o;
        req_type_t kind;
        longint    sa, sb, s, yy, dd;
        int        mm;
        o    = '0;
        kind = req_type_t'(r.req_type);
        sa   = day_number(r.day_a, r.month_a, r.year_a);
        case (kind)
            REQ_ADD, REQ_SUB:
            begin
                s = (kind == REQ_ADD) ? sa + longint'(r.day_count)
                                      : sa - longint'(r.day_count);
                if (s < 0)
                    o.range_error = 1'b1;
                else
                begin
                    yy = (s * 400) / 146097;
                    while (yy > 0 && year_start(yy) > s)
                        yy--;
                    while (year_start(yy + 1) <= s)
                        yy++;
                    if (yy > YearMax)
                        o.range_error = 1'b1;
                    else
                    begin
                        s -= year_start(yy);
                        mm = 0;
                        while (mm < 11 && s >= month_length(mm, yy))
                        begin
                            s -= month_length(mm, yy);
                            mm++;
                        end
                        o.res_day   = 5'(s + 1);
                        o.res_month = 4'(mm);
                        o.res_year  = 14'(yy);
                    end
                end
            end
            REQ_DIFF:
            begin
                sb = day_number(r.day_b, r.month_b, r.year_b);
                dd = (sa > sb) ? sa - sb : sb - sa;
                if (dd > longint'(DiffMax))
                    dd = longint'(DiffMax);
                o.day_diff = 22'(dd);
            end
            default:
            begin
                // Compare uses the raw fields: year first, then month, then day.
                if (r.year_a != r.year_b)
                    o.is_less = r.year_a < r.year_b;
                else if (r.month_a != r.month_b)
                    o.is_less = r.month_a < r.month_b;
                else
                    o.is_less = r.day_a < r.day_b;
                o.is_equal = (r.year_a == r.year_b) && (r.month_a == r.month_b)
                    && (r.day_a == r.day_b);
            end
        endcase
        return o;
    endfunction

    function automatic cda_req_t make_request(req_type_t kind, int da, int ma, int ya,
                                              int db, int mb, int yb, int count);
        cda_req_t r;
        r.req_type  = kind;
        r.day_a     = 5'(da);
        r.month_a   = 4'(ma);
        r.year_a    = 14'(ya);
        r.day_b     = 5'(db);
        r.month_b   = 4'(mb);
        r.year_b    = 14'(yb);
        r.day_count = 20'(count);
        return r;
    endfunction

    task automatic queue_request(cda_req_t r, bit hold);
        queued_req_t q;
        q.req  = r;
        q.hold = hold;
        request_queue.push_back(q);
    endtask

    // Mostly legal dates with random content; about one request in eight is
    // raw noise across the full width of every field.
    function automatic cda_req_t random_request();
        cda_req_t r;
        r = cda_req_t'(68'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 7) != 0)
        begin
            r.month_a = 4'($urandom_range(0, 11));
            r.day_a   = 5'($urandom_range(1, 28));
            r.year_a  = 14'($urandom_range(0, 9999));
            r.month_b = ($urandom_range(0, 3) == 0) ? r.month_a : 4'($urandom_range(0, 11));
            r.day_b   = ($urandom_range(0, 3) == 0) ? r.day_a : 5'($urandom_range(1, 31));
            r.year_b  = ($urandom_range(0, 3) == 0) ? r.year_a
                                                     : 14'($urandom_range(0, 9999));
            if ($urandom_range(0, 1) == 0)
                r.day_count = 20'($urandom_range(0, 4000));
        end
        return r;
    endfunction

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            $display("%0t: mismatch on %s, expected %0d, got %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A long receiver stall lets the block sit with its result held and its input
    // stalled; stretches with no gap on either side send and take back to back.
    function automatic int sender_gap(int index);
        if (index >= 60 && index < 100)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic int receiver_gap(int index);
        if (index == 30)
            return 400;
        if (index >= 120 && index < 160)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Driver: presents requests from the queue and records the expected result
    // of every request the block takes.
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        int  next_gap;
        bit  can_send;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            gap_left     <= 0;
        end
        else
        begin
            can_send = request_queue.size() > 0
                && (!request_queue[0].hold || pending_results.size() == 0);
            if (req_if.valid && req_if.ready)
            begin
                pending_results.push_back(predict_date_result(req_if.data));
                sent_by_type[req_if.data.req_type]++;
                accepted_count++;
                can_send = request_queue.size() > 0
                    && (!request_queue[0].hold || pending_results.size() == 0);
                next_gap = sender_gap(accepted_count);
                if (next_gap == 0 && can_send)
                    req_if.data <= request_queue.pop_front().req;
                else
                begin
                    req_if.valid <= 1'b0;
                    gap_left     <= next_gap;
                end
            end
            else if (!req_if.valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (can_send)
                begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= request_queue.pop_front().req;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks each one against
    // the oldest expectation.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        cda_res_t exp_res;
        int       next_stall;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (res_if.valid && res_if.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected, got %p", $time, res_if.data);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("res_day", exp_res.res_day, res_if.data.res_day);
                check_field("res_month", exp_res.res_month, res_if.data.res_month);
                check_field("res_year", exp_res.res_year, res_if.data.res_year);
                check_field("day_diff", exp_res.day_diff, res_if.data.day_diff);
                check_field("is_less", exp_res.is_less, res_if.data.is_less);
                check_field("is_equal", exp_res.is_equal, res_if.data.is_equal);
                check_field("range_error", exp_res.range_error,
                            res_if.data.range_error);
                if (exp_res.range_error)
                    range_errors_seen++;
            end
            next_stall = receiver_gap(result_count);
            if (next_stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left   <= next_stall;
            end
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            res_if.ready <= (stall_left == 1);
        end
        else
            res_if.ready <= 1'b1;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // Directed requests: range edges, leap rules, odd field values and
        // every request type.
        queue_request(make_request(REQ_ADD, 1, 0, 0, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_SUB, 1, 0, 0, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_ADD, 31, 11, 9999, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_ADD, 1, 0, 0, 1, 0, 0, 1048575), 0);
        queue_request(make_request(REQ_SUB, 31, 11, 9999, 1, 0, 0, 1048575), 0);
        queue_request(make_request(REQ_ADD, 28, 1, 2000, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_ADD, 28, 1, 1900, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_ADD, 28, 1, 2024, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_SUB, 1, 0, 2000, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_ADD, 0, 2, 2001, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_ADD, 31, 1, 2001, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_ADD, 15, 15, 2001, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_ADD, 0, 0, 0, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_ADD, 0, 0, 0, 1, 0, 0, 1), 0);
        queue_request(make_request(REQ_DIFF, 0, 0, 0, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_ADD, 1, 0, 16383, 1, 0, 0, 0), 0);
        queue_request(make_request(REQ_SUB, 1, 0, 16383, 1, 0, 0, 1048575), 0);
        queue_request(make_request(REQ_DIFF, 1, 0, 0, 31, 15, 16383, 0), 0);
        queue_request(make_request(REQ_DIFF, 31, 15, 16383, 0, 0, 0, 0), 0);
        queue_request(make_request(REQ_DIFF, 5, 3, 1999, 5, 3, 1999, 0), 0);
        queue_request(make_request(REQ_DIFF, 1, 0, 0, 31, 11, 9999, 0), 0);
        queue_request(make_request(REQ_CMP, 5, 3, 1999, 5, 3, 1999, 0), 0);
        queue_request(make_request(REQ_CMP, 5, 3, 1998, 5, 3, 1999, 0), 0);
        queue_request(make_request(REQ_CMP, 5, 4, 1999, 5, 3, 1999, 0), 0);
        queue_request(make_request(REQ_CMP, 4, 3, 1999, 5, 3, 1999, 0), 0);
        queue_request(make_request(REQ_CMP, 31, 15, 16383, 0, 0, 0, 0), 0);

        // Random part; one request waits for the block to drain completely.
        for (int i = 0; i < NumRandom; i++)
            queue_request(random_request(), i == 80);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (request_queue.size() == 0 && !req_if.valid && pending_results.size() == 0);
        repeat (20) @(posedge clk);

        $display("tb: %0d requests checked (add %0d, sub %0d, diff %0d, cmp %0d)",
                 accepted_count, sent_by_type[REQ_ADD], sent_by_type[REQ_SUB],
                 sent_by_type[REQ_DIFF], sent_by_type[REQ_CMP]);
        $display("tb: %0d results, %0d range errors, %0d mismatches",
                 result_count, range_errors_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
